FILE: src/plc_pkg.sv
// plc_pkg: shared constants, codes and types for the positional byte list
// no dependencies; imported by the core and its checker

package plc_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = 8;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 7;
  localparam int CHAR_W   = 8;
  localparam int STAT_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_READ     = 2'd2,
    FN_READ_ALL = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_REM  = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

endpackage

FILE: src/positional_char_list_core.sv
// positional_char_list_core: ordered byte list with insert, remove, read one, read all
// depends on plc_pkg and plc_ram
//
//   channel   signals                          handshake
//   command   func, position, char_in          start & !busy
//   result    status, char_out, last           strobe, one cycle, no stall
//
// an error or empty result comes in the cycle after the command; read one reads its entry through the ram
// insert moves entries position..count up, none when appending, remove those after
// position down, with one ram read and one ram write per cycle while entries are shifted
// read all gives one result per cycle, each read through the registered ram read port
// reset is synchronous and empties the list; no clearing pass of the ram
// busy is high while a command is at work; results cannot be held off

module positional_char_list_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [plc_pkg::FUNC_W-1:0]  func,
  input  logic [plc_pkg::POS_W-1:0]   position,
  input  logic [plc_pkg::CHAR_W-1:0]  char_in,
  output logic                        strobe,
  output logic [plc_pkg::STAT_W-1:0]  status,
  output logic [plc_pkg::CHAR_W-1:0]  char_out,
  output logic                        last
);

  import plc_pkg::*;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  lim;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] val;
  logic              is_rem;
  logic              first;
  logic              pend;
  logic              pend_first;
  logic              pend_last;
  logic [ADDR_W-1:0] pend_addr;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  logic              accept;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              ins_go;
  logic              rem_go;
  logic              dump_go;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pos_c   = CMP_W'(position);
  assign cnt_c   = CMP_W'(count);
  assign ins_go  = (ptr >= pos_r);
  assign rem_go  = (ptr < lim);
  assign dump_go = (ptr < count);

  plc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pend_addr;
    wdata = rdata;
    case (state)
      S_INS: begin
        raddr = ADDR_W'(ptr - 1'b1);
        if (pend) begin
          we = 1'b1;
        end else if (!ins_go) begin
          we    = 1'b1;
          waddr = ADDR_W'(pos_r - 1'b1);
          wdata = ch;
        end
      end
      S_REM: begin
        raddr = ADDR_W'(ptr);
        we    = pend && !pend_first && is_rem;
      end
      S_DUMP: begin
        raddr = ADDR_W'(ptr);
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (accept) begin
            case (func_t'(func))
              FN_INSERT: begin
                if (position == '0 || pos_c > cnt_c + 1'b1) begin
                  strobe <= 1'b1; status <= ST_BADPOS; char_out <= '0; last <= 1'b1;
                end else if (cnt_c == CMP_W'(CAPACITY)) begin
                  strobe <= 1'b1; status <= ST_FULL; char_out <= '0; last <= 1'b1;
                end else begin
                  state <= S_INS;
                  ptr   <= count;
                  pos_r <= CNT_W'(position);
                  ch    <= char_in;
                end
              end
              FN_REMOVE, FN_READ: begin
                if (position == '0 || pos_c > cnt_c) begin
                  strobe <= 1'b1; status <= ST_BADPOS; char_out <= '0; last <= 1'b1;
                end else begin
                  state  <= S_REM;
                  pos_r  <= CNT_W'(position);
                  ptr    <= CNT_W'(position - 1'b1);
                  is_rem <= (func_t'(func) == FN_REMOVE);
                  lim    <= (func_t'(func) == FN_REMOVE) ? count : CNT_W'(position);
                  first  <= 1'b1;
                end
              end
              FN_READ_ALL: begin
                if (count == '0) begin
                  strobe <= 1'b1; status <= ST_EMPTY; char_out <= '0; last <= 1'b1;
                end else begin
                  state <= S_DUMP;
                  ptr   <= '0;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS: begin
          pend      <= ins_go;
          pend_addr <= ADDR_W'(ptr);
          if (ins_go) begin
            ptr <= ptr - 1'b1;
          end else if (!pend) begin
            count    <= count + 1'b1;
            strobe   <= 1'b1;
            status   <= ST_OK;
            char_out <= ch;
            last     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_REM: begin
          pend       <= rem_go;
          pend_first <= first;
          pend_addr  <= ADDR_W'(ptr - 1'b1);
          if (pend && pend_first) begin
            val <= rdata;
          end
          if (rem_go) begin
            ptr   <= ptr + 1'b1;
            first <= 1'b0;
          end else if (!pend) begin
            if (is_rem) begin
              count <= count - 1'b1;
            end
            strobe   <= 1'b1;
            status   <= ST_OK;
            char_out <= val;
            last     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_DUMP: begin
          pend      <= dump_go;
          pend_last <= (ptr == count - 1'b1);
          if (dump_go) begin
            ptr <= ptr + 1'b1;
          end
          if (pend) begin
            strobe   <= 1'b1;
            status   <= ST_OK;
            char_out <= rdata;
            last     <= pend_last;
            if (!dump_go) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/plc_ram.sv
// plc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/plc_checker.sv
// plc_checker: port-level assertions for the positional byte list core
// depends on plc_pkg; bound to positional_char_list_core below

module plc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [plc_pkg::FUNC_W-1:0]  func,
  input logic [plc_pkg::POS_W-1:0]   position,
  input logic [plc_pkg::CHAR_W-1:0]  char_in,
  input logic                        strobe,
  input logic [plc_pkg::STAT_W-1:0]  status,
  input logic [plc_pkg::CHAR_W-1:0]  char_out,
  input logic                        last
);

  import plc_pkg::*;

  // an accepted transaction either answers at once or keeps the core busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || strobe))
    else $error("accepted transaction left no trace");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != ST_OK) |-> (last && char_out == '0))
    else $error("error result not final or carries a byte");

  // read all streams without gaps until last
  a_stream_dense: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && status == ST_OK))
    else $error("gap inside a read-all stream");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !strobe))
    else $error("core not idle after reset");

  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("core idle in the middle of a stream");

endmodule

bind positional_char_list_core plc_checker u_plc_checker (.*);
